// ===== rtl/lsir_pkg.sv =====
// Shared definitions for the link status indicator registry.
// Codes, colors, default sizes and the controller/datapath command and status types.
// No dependencies.
package lsir_pkg;

	localparam int LSIR_ENTRIES  = 8;
	localparam int LSIR_PROFILES = 5;
	localparam int STATUS_FIELDS = 5;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_PIXEL_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_PRESENT    = 1'd1;

	localparam logic [1:0] CMD_ON      = 2'd0;
	localparam logic [1:0] CMD_OFF     = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;
	localparam logic [1:0] CMD_REPAINT = 2'd3;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_NO_REMOTE = 2'd2;

	localparam logic [2:0] SRC_USB = 3'd5;

	localparam logic [1:0] USB_POWERED = 2'd1;
	localparam logic [1:0] USB_HID     = 2'd2;
	localparam logic [1:0] LINK_PAIRED    = 2'd1;
	localparam logic [1:0] LINK_CONNECTED = 2'd2;

	localparam logic [23:0] COL_WHITE = 24'hffffff;
	localparam logic [23:0] COL_GREEN = 24'h00ff68;
	localparam logic [23:0] COL_RED   = 24'hff0000;
	localparam logic [23:0] COL_LILAC = 24'h6b1fce;

	// controller -> datapath
	typedef struct packed {
		logic in_ready;
		logic capture;
		logic idx_inc;
		logic scan_step;
		logic rd_en;
		logic note_match;
		logic load_bulk;
		logic load_single;
	} lsir_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic bulk;
		logic active;
		logic match;
		logic at_end;
	} lsir_stat_t;

endpackage

// ===== rtl/lsir_req_if.sv =====
// Request channel: one command item with its link status snapshot.
// Depends on nothing.
interface lsir_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [7:0]  position;
	logic [2:0]  link_source;
	logic [1:0]  usb_link;
	logic        active_transport;
	logic [2:0]  active_profile;
	logic [9:0]  profile_status;

	modport source (output valid, command, position, link_source, usb_link, active_transport,
		active_profile, profile_status, input ready);
	modport sink (input valid, command, position, link_source, usb_link, active_transport,
		active_profile, profile_status, output ready);
endinterface

// ===== rtl/lsir_rsp_if.sv =====
// Result channel: one pixel write item.
// Depends on nothing.
interface lsir_rsp_if;
	logic        valid;
	logic        ready;
	logic        pixel_write;
	logic        to_remote;
	logic [7:0]  pixel_index;
	logic        clear_pixel;
	logic [23:0] color;
	logic [1:0]  status;
	logic        last;

	modport source (output valid, pixel_write, to_remote, pixel_index, clear_pixel, color,
		status, last, input ready);
	modport sink (input valid, pixel_write, to_remote, pixel_index, clear_pixel, color,
		status, last, output ready);
endinterface

// ===== rtl/link_status_indicator_registry_core.sv =====
// Top level of the link status indicator registry.
// Depends on lsir_pkg, lsir_req_if, lsir_rsp_if, lsir_ctrl and lsir_dp.
//
// Channel   Dir  Handshake    Payload
// request   in   valid/ready  command, position, link_source, usb_link, active_transport,
//                             active_profile, profile_status
// result    out  valid/ready  pixel_write, to_remote, pixel_index, clear_pixel, color,
//                             status, last
// cfg       in   cfg_we       cfg_index (0 local pixel count, 1 remote present), cfg_data
//
// Sequencing: one item at a time. The table has a single read port and is walked one
// entry per step: a free slot takes a scan state, an active slot a scan and an eval
// state (read, then compare), plus an out state when a bulk walk emits it. On/off
// load their result in a final state and stop at a match.
// Reset: arst_n clears the active bits, the controller and the result valid; config
// goes to local pixel count 0, remote present 1. Entry contents are not reset.
// Stalls: a held result stops the walk at the next emit; a new item is taken
// while the last result of the previous one still waits in the result register.
module link_status_indicator_registry_core
	import lsir_pkg::*;
#(
	parameter int ENTRIES  = LSIR_ENTRIES,
	parameter int PROFILES = LSIR_PROFILES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	lsir_req_if.sink              request,
	lsir_rsp_if.source            result
);

	lsir_cmd_t  cmd;   // sequencer strobes
	lsir_stat_t stat;  // table and channel status

	lsir_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	lsir_dp #(
		.ENTRIES  (ENTRIES),
		.PROFILES (PROFILES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.request   (request),
		.result    (result),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// ===== rtl/lsir_ctrl.sv =====
// Sequencer for the indicator registry: walks the table one entry at a time.
// Depends on lsir_pkg (command and status structs).
module lsir_ctrl
	import lsir_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  lsir_stat_t stat,
	output lsir_cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_EVAL  = 5'b00100,
		ST_OUT   = 5'b01000,
		ST_FINAL = 5'b10000
	} lsir_state_t;

	lsir_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (stat.in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.active) begin
					cmd.rd_en = 1'b1;
					state_d   = ST_EVAL;
				end else begin
					cmd.scan_step = 1'b1;
					if (stat.at_end) begin
						state_d = stat.bulk ? ST_IDLE : ST_FINAL;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			ST_EVAL: begin
				if (stat.bulk) begin
					state_d = ST_OUT;
				end else if (stat.match) begin
					cmd.note_match = 1'b1;
					state_d        = ST_FINAL;
				end else if (stat.at_end) begin
					state_d = ST_FINAL;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_SCAN;
				end
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.load_bulk = 1'b1;
					if (stat.at_end) begin
						state_d = ST_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = ST_SCAN;
					end
				end
			end
			ST_FINAL: begin
				if (stat.out_free) begin
					cmd.load_single = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/lsir_dp.sv =====
// Datapath for the indicator registry: entry table, color ladder, strip routing,
// config registers and the result register. Depends on lsir_pkg and both channel interfaces.
module lsir_dp
	import lsir_pkg::*;
#(
	parameter int ENTRIES  = LSIR_ENTRIES,
	parameter int PROFILES = LSIR_PROFILES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	lsir_req_if.sink              request,
	lsir_rsp_if.source            result,
	input  lsir_cmd_t             cmd,
	output lsir_stat_t            stat
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// config
	logic [7:0] lpc_q;
	logic       rp_q;

	// captured item
	logic [1:0] cmd_q;
	logic [7:0] pos_q;
	logic [2:0] src_q;
	logic [1:0] usb_q;
	logic       trans_q;
	logic [2:0] actp_q;
	logic [9:0] pstat_q;

	// scan state
	logic [IW-1:0]      idx_q;
	logic [IW-1:0]      free_idx_q;
	logic [IW-1:0]      match_idx_q;
	logic               free_found_q;
	logic               match_found_q;
	logic [ENTRIES-1:0] active_q;

	// table storage: {position, source}
	logic [10:0] mem_q [ENTRIES];
	logic [10:0] rd_q;
	logic [7:0]  rd_pos;
	logic [2:0]  rd_src;
	logic        mem_we;

	// result register
	logic        out_valid_q;
	logic        pw_q, rem_q, clr_q, last_q;
	logic [7:0]  pidx_q;
	logic [23:0] col_q;
	logic [1:0]  st_q;

	logic               load;
	logic               out_free;
	logic [ENTRIES-1:0] above;
	logic [7:0]         em_pos;
	logic [2:0]         em_src;
	logic               em_clear, em_full, em_last;
	logic               em_pw, em_rem;
	logic [7:0]         em_idx;
	logic [23:0]        em_col;
	logic [1:0]         em_st;

	function automatic logic [23:0] pick_color(input logic [2:0] src);
		logic [1:0] st;
		logic [23:0] c;
		st = '0;
		if (src == SRC_USB) begin
			if (usb_q == USB_HID && !trans_q) c = COL_WHITE;
			else if (usb_q == USB_HID) c = COL_GREEN;
			else if (usb_q == USB_POWERED) c = COL_RED;
			else c = COL_LILAC;
		end else begin
			for (int k = 0; k < STATUS_FIELDS; k++) begin
				if (k < PROFILES && src == 3'(k)) st = pstat_q[2*k +: 2];
			end
			if (st == LINK_CONNECTED && trans_q && actp_q == src) c = COL_WHITE;
			else if (st == LINK_CONNECTED) c = COL_GREEN;
			else if (st == LINK_PAIRED) c = COL_RED;
			else c = COL_LILAC;
		end
		return c;
	endfunction

	assign rd_pos = rd_q[10:3];
	assign rd_src = rd_q[2:0];

	assign out_free = !out_valid_q || result.ready;
	assign load     = cmd.load_bulk || cmd.load_single;
	assign mem_we   = cmd.load_single && cmd_q == CMD_ON && !match_found_q && free_found_q;

	assign request.ready = cmd.in_ready;

	assign stat.in_valid = request.valid;
	assign stat.out_free = out_free;
	assign stat.bulk     = cmd_q[1];
	assign stat.active   = active_q[idx_q];
	assign stat.match    = rd_pos == pos_q && rd_src == src_q;
	assign stat.at_end   = idx_q == IW'(ENTRIES - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpc_q <= '0;
			rp_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOCAL_PIXEL_COUNT: lpc_q <= cfg_data;
				CFG_REMOTE_PRESENT:    rp_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q   <= request.command;
			pos_q   <= request.position;
			src_q   <= request.link_source;
			usb_q   <= request.usb_link;
			trans_q <= request.active_transport;
			actp_q  <= request.active_profile;
			pstat_q <= request.profile_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= '0;
			free_idx_q    <= '0;
			match_idx_q   <= '0;
			free_found_q  <= 1'b0;
			match_found_q <= 1'b0;
			active_q      <= '0;
		end else begin
			if (cmd.capture) begin
				idx_q         <= '0;
				free_found_q  <= 1'b0;
				match_found_q <= 1'b0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.scan_step && !free_found_q && !active_q[idx_q]) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_q;
			end
			if (cmd.note_match) begin
				match_found_q <= 1'b1;
				match_idx_q   <= idx_q;
			end
			if (mem_we) begin
				active_q[free_idx_q] <= 1'b1;
			end
			if (cmd.load_single && cmd_q == CMD_OFF && match_found_q) begin
				active_q[match_idx_q] <= 1'b0;
			end
			if (cmd.load_bulk && cmd_q == CMD_CLEAR) begin
				active_q[idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[free_idx_q] <= {pos_q, src_q};
		end
		if (cmd.rd_en) begin
			rd_q <= mem_q[idx_q];
		end
	end

	// any active entry past the current one
	always_comb begin
		for (int j = 0; j < ENTRIES; j++) begin
			above[j] = active_q[j] && (j > int'(idx_q));
		end
	end

	always_comb begin
		em_pos   = cmd.load_bulk ? rd_pos : pos_q;
		em_src   = cmd.load_bulk ? rd_src : src_q;
		em_clear = cmd_q == CMD_OFF || cmd_q == CMD_CLEAR;
		em_full  = cmd_q == CMD_ON && !match_found_q && !free_found_q;
		em_last  = cmd.load_single || ~|above;
		if (em_pos < lpc_q) begin
			em_pw  = 1'b1;
			em_rem = 1'b0;
			em_idx = em_pos;
			em_st  = STATUS_OK;
		end else begin
			em_pw  = rp_q;
			em_rem = 1'b1;
			em_idx = em_pos - lpc_q;
			em_st  = rp_q ? STATUS_OK : STATUS_NO_REMOTE;
		end
		em_col = em_clear ? 24'd0 : pick_color(em_src);
		if (cmd.load_single && em_full) begin
			em_pw    = 1'b0;
			em_rem   = 1'b0;
			em_idx   = '0;
			em_clear = 1'b0;
			em_col   = '0;
			em_st    = STATUS_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pw_q   <= em_pw;
			rem_q  <= em_rem;
			pidx_q <= em_idx;
			clr_q  <= em_clear;
			col_q  <= em_col;
			st_q   <= em_st;
			last_q <= em_last;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.pixel_write = pw_q;
	assign result.to_remote   = rem_q;
	assign result.pixel_index = pidx_q;
	assign result.clear_pixel = clr_q;
	assign result.color       = col_q;
	assign result.status      = st_q;
	assign result.last        = last_q;

endmodule
